// File: design/hbfd_pkg.sv
// hbfd_pkg: shared types and constants for the http body framing decoder
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package hbfd_pkg;

  // byte and length widths fixed by the header interface
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 32;

  // command codes
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // result classification codes
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_FRAMING = 2'd1;
  localparam logic [1:0] KIND_LINE    = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  // line delimiters
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  // classified item as it travels from front to back
  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] data_byte;
    logic              is_hex;
    logic [3:0]        hex_val;
    logic              is_cr;
    logic              is_lf;
    logic              chunked;
    logic              keep;
    logic [LEN_W-1:0]  length;
  } item_t;

  // queue status seen by the back end
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

endpackage

// File: design/hbfd_front.sv
// hbfd_front: accepts input transfers and classifies each byte
// depends on hbfd_pkg; feeds hbfd_queue
`timescale 1ns / 1ps

module hbfd_front import hbfd_pkg::*; (
  input  logic              in_valid_i,
  input  logic              op_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              chunked_mode_i,
  input  logic              keep_alive_i,
  input  logic [LEN_W-1:0]  content_length_i,
  input  q_stat_t           q_stat_i,
  output logic              in_stall_o,
  output logic              push_o,
  output item_t             item_o
);

  logic [BYTE_W-1:0] b;
  logic              dig, low, upp;

  assign b = data_byte_i;

  // hex digit decode
  always_comb begin
    dig = (b >= 8'h30) && (b <= 8'h39);
    low = (b >= 8'h61) && (b <= 8'h66);
    upp = (b >= 8'h41) && (b <= 8'h46);
    item_o.op        = op_i;
    item_o.data_byte = b;
    item_o.is_hex    = dig | low | upp;
    if (dig) begin
      item_o.hex_val = b[3:0];
    end else begin
      item_o.hex_val = b[3:0] + 4'd9;
    end
    item_o.is_cr   = (b == CHAR_CR);
    item_o.is_lf   = (b == CHAR_LF);
    item_o.chunked = chunked_mode_i;
    item_o.keep    = keep_alive_i;
    item_o.length  = content_length_i;
  end

  // input transfer goes straight into the queue
  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i & ~q_stat_i.full;

endmodule

// File: design/hbfd_queue.sv
// hbfd_queue: two-entry queue of classified items between front and back
// depends on hbfd_pkg
`timescale 1ns / 1ps

module hbfd_queue import hbfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  item_t   item_i,
  input  logic    pop_i,
  output item_t   head_o,
  output q_stat_t stat_o
);

  item_t      entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  assign head_o           = entry_q[rd_ptr_q];
  assign stat_o.not_empty = (count_q != 2'd0);
  assign stat_o.full      = (count_q == 2'd2);

endmodule

// File: design/hbfd_back.sv
// hbfd_back: framing state machine and output register
// depends on hbfd_pkg; drains hbfd_queue
`timescale 1ns / 1ps

module hbfd_back import hbfd_pkg::*; #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  item_t             head_i,
  input  q_stat_t           q_stat_i,
  output logic              pop_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic [1:0]        kind_o,
  output logic              body_done_o,
  output logic              in_body_o,
  output logic              size_overflow_o
);

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_DATA    = 3'd1,
    PH_SKIP_CR = 3'd2,
    PH_SKIP_LF = 3'd3,
    PH_TRAILER = 3'd4
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [SIZE_BITS-1:0] chunk_rem_q, chunk_rem_d, chunk_dec;
  logic [LEN_W-1:0]     body_rem_q, body_rem_d, body_dec;
  logic                 body_mode_q, body_mode_d;
  logic                 chunked_q, chunked_d;
  logic                 keep_q, keep_d;
  logic                 last_cr_q, last_cr_d;
  logic                 size_ended_q, size_ended_d;

  logic              out_valid_q;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [1:0]        kind_q, kind_d;
  logic              done_q, done_d;
  logic              ovf_q, ovf_d;

  // take the next item whenever the output slot frees up
  assign pop_o = q_stat_i.not_empty & (~out_valid_q | ~out_stall_i);

  // saturating count-downs
  assign chunk_dec = (chunk_rem_q != '0) ? chunk_rem_q - 1'b1 : chunk_rem_q;
  assign body_dec  = (body_rem_q != '0) ? body_rem_q - 1'b1 : body_rem_q;

  // next state and result for the head item
  always_comb begin
    phase_d      = phase_q;
    chunk_rem_d  = chunk_rem_q;
    body_rem_d   = body_rem_q;
    body_mode_d  = body_mode_q;
    chunked_d    = chunked_q;
    keep_d       = keep_q;
    last_cr_d    = last_cr_q;
    size_ended_d = size_ended_q;
    byte_d       = head_i.data_byte;
    kind_d       = KIND_LINE;
    done_d       = 1'b0;
    ovf_d        = 1'b0;

    if (head_i.op == OP_BEGIN) begin
      chunked_d    = head_i.chunked;
      keep_d       = head_i.keep;
      body_rem_d   = head_i.length;
      phase_d      = PH_SIZE;
      chunk_rem_d  = '0;
      last_cr_d    = 1'b0;
      size_ended_d = 1'b0;
      body_mode_d  = (head_i.length != '0) | ~head_i.keep | head_i.chunked;
      done_d       = ~head_i.chunked & (head_i.length == '0);
      byte_d       = '0;
      kind_d       = KIND_NONE;
    end else if (body_mode_q) begin
      if (chunked_q) begin
        kind_d = KIND_FRAMING;
        case (phase_q)
          PH_DATA: begin
            kind_d      = KIND_PAYLOAD;
            chunk_rem_d = chunk_dec;
            if (chunk_dec == '0) begin
              phase_d = PH_SKIP_CR;
            end
          end
          PH_SKIP_CR: begin
            phase_d = PH_SKIP_LF;
          end
          PH_SKIP_LF: begin
            phase_d = PH_SIZE;
          end
          PH_TRAILER: begin
            if (head_i.is_lf && last_cr_q) begin
              last_cr_d   = 1'b0;
              done_d      = 1'b1;
              body_mode_d = 1'b0;
              chunked_d   = 1'b0;
              phase_d     = PH_SIZE;
            end else begin
              last_cr_d = head_i.is_cr;
            end
          end
          default: begin
            // size line: hex digits until ';' or any other byte, ends at crlf
            if (head_i.is_lf && last_cr_q) begin
              last_cr_d    = 1'b0;
              size_ended_d = 1'b0;
              phase_d      = (chunk_rem_q == '0) ? PH_TRAILER : PH_DATA;
            end else begin
              if (!size_ended_q) begin
                if (head_i.is_hex) begin
                  if (chunk_rem_q[SIZE_BITS-1 -: 4] != 4'd0) begin
                    chunk_rem_d = '1;
                    ovf_d       = 1'b1;
                  end else begin
                    chunk_rem_d = {chunk_rem_q[SIZE_BITS-5:0], head_i.hex_val};
                  end
                end else begin
                  size_ended_d = 1'b1;
                end
              end
              last_cr_d = head_i.is_cr;
            end
          end
        endcase
      end else if (!keep_q) begin
        // close-delimited: all bytes payload, done once when count hits zero
        kind_d     = KIND_PAYLOAD;
        body_rem_d = body_dec;
        done_d     = (body_rem_q == {{(LEN_W-1){1'b0}}, 1'b1});
      end else begin
        kind_d     = KIND_PAYLOAD;
        body_rem_d = body_dec;
        if (body_dec == '0) begin
          done_d      = 1'b1;
          body_mode_d = 1'b0;
        end
      end
    end
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SIZE;
      chunk_rem_q  <= '0;
      body_rem_q   <= '0;
      body_mode_q  <= 1'b0;
      chunked_q    <= 1'b0;
      keep_q       <= 1'b0;
      last_cr_q    <= 1'b0;
      size_ended_q <= 1'b0;
    end else if (pop_o) begin
      phase_q      <= phase_d;
      chunk_rem_q  <= chunk_rem_d;
      body_rem_q   <= body_rem_d;
      body_mode_q  <= body_mode_d;
      chunked_q    <= chunked_d;
      keep_q       <= keep_d;
      last_cr_q    <= last_cr_d;
      size_ended_q <= size_ended_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  logic in_body_q;
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_q    <= byte_d;
      kind_q    <= kind_d;
      done_q    <= done_d;
      in_body_q <= body_mode_d;
      ovf_q     <= ovf_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = byte_q;
  assign kind_o          = kind_q;
  assign body_done_o     = done_q;
  assign in_body_o       = in_body_q;
  assign size_overflow_o = ovf_q;

endmodule

// File: design/http_body_framing_decoder.sv
// http_body_framing_decoder: top level of the http body framing decoder
// depends on hbfd_pkg, hbfd_front, hbfd_queue, hbfd_back
//
//   channel | handshake             | fields
//   --------+-----------------------+-----------------------------------------------
//   in      | in_valid_i/in_stall_o | op, data_byte, chunked_mode, keep_alive,
//           |                       | content_length
//   out     | out_valid_o/out_stall_i | out_byte, kind, body_done, in_body,
//           |                       | size_overflow
//
// one item per cycle sustained while out_stall_i stays low; a result passes through
// the two-entry queue, then the output register, before it can transfer.
// the framing state update in the back end, made for each popped item, sets the rate.
// reset clears the queue, the decoder state and the output valid; no clearing pass.
// an output stall holds the result; the queue then fills and in_stall_o rises
// after at most two further transfers.
`timescale 1ns / 1ps

module http_body_framing_decoder import hbfd_pkg::*; #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              op_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              chunked_mode_i,
  input  logic              keep_alive_i,
  input  logic [LEN_W-1:0]  content_length_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic [1:0]        kind_o,
  output logic              body_done_o,
  output logic              in_body_o,
  output logic              size_overflow_o
);

  item_t   front_item, head_item;
  q_stat_t q_stat;
  logic    push, pop;

  // classify incoming transfers
  hbfd_front u_front (
    .in_valid_i       (in_valid_i),
    .op_i             (op_i),
    .data_byte_i      (data_byte_i),
    .chunked_mode_i   (chunked_mode_i),
    .keep_alive_i     (keep_alive_i),
    .content_length_i (content_length_i),
    .q_stat_i         (q_stat),
    .in_stall_o       (in_stall_o),
    .push_o           (push),
    .item_o           (front_item)
  );

  // decoupling queue
  hbfd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .head_o (head_item),
    .stat_o (q_stat)
  );

  // framing state machine
  hbfd_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head_item),
    .q_stat_i        (q_stat),
    .pop_o           (pop),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .out_byte_o      (out_byte_o),
    .kind_o          (kind_o),
    .body_done_o     (body_done_o),
    .in_body_o       (in_body_o),
    .size_overflow_o (size_overflow_o)
  );

endmodule

// File: design/hbfd_checker.sv
// hbfd_checker: port-level assertions for the http body framing decoder
// depends on hbfd_pkg; bound to http_body_framing_decoder
`timescale 1ns / 1ps

module hbfd_checker import hbfd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [BYTE_W-1:0] out_byte_o,
  input logic [1:0]        kind_o,
  input logic              body_done_o,
  input logic              in_body_o,
  input logic              size_overflow_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(kind_o))
    else $error("stalled result changed");

  // begin results carry no byte
  a_begin_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_NONE) |-> (out_byte_o == '0) && !size_overflow_o)
    else $error("begin result carries a byte");

  // overflow only on size-line framing inside a body
  a_ovf_framing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && size_overflow_o |-> (kind_o == KIND_FRAMING) && in_body_o)
    else $error("overflow outside size line");

  // line-parser bytes never touch the body
  a_line_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_LINE) |-> !in_body_o && !body_done_o)
    else $error("line byte inside body");

  // payload leaves body mode only when the body completes
  a_payload_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_PAYLOAD) |-> in_body_o || body_done_o)
    else $error("payload outside body");

endmodule

bind http_body_framing_decoder hbfd_checker u_hbfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_byte_o      (out_byte_o),
  .kind_o          (kind_o),
  .body_done_o     (body_done_o),
  .in_body_o       (in_body_o),
  .size_overflow_o (size_overflow_o)
);

// File: verif/http_body_framing_decoder_tb.sv
// http_body_framing_decoder_tb: self-checking testbench for the http body framing decoder
// depends on hbfd_pkg and http_body_framing_decoder; directed table, then random messages
// checked against a cycle-free model of the framing state machine
`timescale 1ns / 1ps

module http_body_framing_decoder_tb;
  import hbfd_pkg::*;

  // chunk phases of the framing state machine
  localparam logic [2:0] PH_SIZE    = 3'd0;
  localparam logic [2:0] PH_DATA    = 3'd1;
  localparam logic [2:0] PH_SKIP_CR = 3'd2;
  localparam logic [2:0] PH_SKIP_LF = 3'd3;
  localparam logic [2:0] PH_TRAILER = 3'd4;

  localparam logic [LEN_W-1:0]  SIZE_MAX  = 32'hFFFF_FFFF;
  localparam logic [BYTE_W-1:0] CHAR_SEMI = 8'h3B;
  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
  localparam int RAND_ITEMS     = 1750;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [1:0]        kind;
    logic              done;
    logic              in_body;
    logic              ovf;
  } result_t;

  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] data_byte;
    logic              chunked;
    logic              keep;
    logic [LEN_W-1:0]  len;
    logic              hold;
    logic              typed;
    result_t           known;
  } stim_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              op_i;
  logic [BYTE_W-1:0] data_byte_i;
  logic              chunked_mode_i;
  logic              keep_alive_i;
  logic [LEN_W-1:0]  content_length_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [BYTE_W-1:0] out_byte_o;
  logic [1:0]        kind_o;
  logic              body_done_o;
  logic              in_body_o;
  logic              size_overflow_o;

  // model state of the decoder
  logic             body_on    = 1'b0;
  logic [2:0]       phase      = PH_SIZE;
  logic [LEN_W-1:0] chunk_left = '0;
  logic [LEN_W-1:0] body_left  = '0;
  logic             chunked_st = 1'b0;
  logic             keep_st    = 1'b0;
  logic             cr_seen    = 1'b0;
  logic             size_done  = 1'b0;

  result_t pending_results[$];
  stim_t   dir_tab[$];
  stim_t   traffic_q[$];
  stim_t   msg_q[$];
  int      err_cnt = 0;
  bit      no_idle = 1'b0;

  http_body_framing_decoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .data_byte_i      (data_byte_i),
    .chunked_mode_i   (chunked_mode_i),
    .keep_alive_i     (keep_alive_i),
    .content_length_i (content_length_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .kind_o           (kind_o),
    .body_done_o      (body_done_o),
    .in_body_o        (in_body_o),
    .size_overflow_o  (size_overflow_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hex digit value, -1 for any other byte
  function automatic int hex_digit(logic [BYTE_W-1:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  // advance the decoder model by one transfer and return its result
  function automatic result_t frame_step(stim_t s);
    result_t r;
    int h;
    r = '0;
    r.out_byte = s.data_byte;
    r.kind = KIND_LINE;
    if (s.op == OP_BEGIN) begin
      chunked_st = s.chunked;
      keep_st = s.keep;
      body_left = s.len;
      phase = PH_SIZE;
      chunk_left = '0;
      cr_seen = 1'b0;
      size_done = 1'b0;
      body_on = (s.len != 0) || !s.keep || s.chunked;
      r.done = !s.chunked && (s.len == 0);
      r.out_byte = '0;
      r.kind = KIND_NONE;
    end else if (body_on) begin
      if (chunked_st) begin
        r.kind = KIND_FRAMING;
        case (phase)
          PH_DATA: begin
            r.kind = KIND_PAYLOAD;
            if (chunk_left != 0) chunk_left--;
            if (chunk_left == 0) phase = PH_SKIP_CR;
          end
          PH_SKIP_CR: phase = PH_SKIP_LF;
          PH_SKIP_LF: phase = PH_SIZE;
          PH_TRAILER: begin
            if (s.data_byte == CHAR_LF && cr_seen) begin
              cr_seen = 1'b0;
              r.done = 1'b1;
              body_on = 1'b0;
              chunked_st = 1'b0;
              phase = PH_SIZE;
            end else begin
              cr_seen = (s.data_byte == CHAR_CR);
            end
          end
          // size line, also for the unused phase codes
          default: begin
            if (s.data_byte == CHAR_LF && cr_seen) begin
              cr_seen = 1'b0;
              size_done = 1'b0;
              phase = (chunk_left == 0) ? PH_TRAILER : PH_DATA;
            end else begin
              h = hex_digit(s.data_byte);
              if (!size_done) begin
                if (h >= 0) begin
                  if (chunk_left > (SIZE_MAX >> 4)) begin
                    chunk_left = SIZE_MAX;
                    r.ovf = 1'b1;
                  end else begin
                    chunk_left = {chunk_left[LEN_W-5:0], h[3:0]};
                  end
                end else begin
                  size_done = 1'b1;
                end
              end
              cr_seen = (s.data_byte == CHAR_CR);
            end
          end
        endcase
      end else if (!keep_st) begin
        // length body that runs to connection close
        r.kind = KIND_PAYLOAD;
        if (body_left != 0) begin
          body_left--;
          if (body_left == 0) r.done = 1'b1;
        end
      end else begin
        r.kind = KIND_PAYLOAD;
        if (body_left != 0) body_left--;
        if (body_left == 0) begin
          r.done = 1'b1;
          body_on = 1'b0;
        end
      end
    end
    r.in_body = body_on;
    return r;
  endfunction

  // directed table rows, checked by the model
  function automatic void row(logic op, logic [7:0] b, logic c, logic k, logic [31:0] len);
    stim_t s;
    s = '0;
    s.op = op;
    s.data_byte = b;
    s.chunked = c;
    s.keep = k;
    s.len = len;
    dir_tab.push_back(s);
  endfunction

  // directed table rows with the result written out
  function automatic void row_exp(logic op, logic [7:0] b, logic c, logic k, logic [31:0] len,
                                  logic [1:0] ek, logic ed, logic eib, logic eov);
    row(op, b, c, k, len);
    dir_tab[$].typed = 1'b1;
    dir_tab[$].known.out_byte = (op == OP_BYTE) ? b : 8'h00;
    dir_tab[$].known.kind = ek;
    dir_tab[$].known.done = ed;
    dir_tab[$].known.in_body = eib;
    dir_tab[$].known.ovf = eov;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    stim_t s;
    s = '0;
    s.op = OP_BYTE;
    s.data_byte = b;
    msg_q.push_back(s);
  endfunction

  function automatic void put_begin(logic c, logic k, logic [31:0] len);
    stim_t s;
    s = '0;
    s.op = OP_BEGIN;
    s.chunked = c;
    s.keep = k;
    s.len = len;
    s.data_byte = 8'($urandom());
    msg_q.push_back(s);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib, logic upper);
    if (nib < 10) return CHAR_ZERO + nib;
    return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // hex size, optional leading zeros and extension, CR LF
  function automatic void put_size_line(logic [31:0] sz);
    int nd;
    nd = 1;
    while (nd < 8 && (sz >> (4 * nd)) != 0) nd++;
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) put_byte(CHAR_ZERO);
    for (int i = nd - 1; i >= 0; i--) put_byte(hex_char(sz[4*i +: 4], 1'($urandom_range(1))));
    if ($urandom_range(4) == 0) begin
      put_byte(CHAR_SEMI);
      repeat ($urandom_range(0, 4)) put_byte(printable());
    end
    put_byte(CHAR_CR);
    put_byte(CHAR_LF);
  endfunction

  // chunked message with random content; a chunk's closing CR LF is sometimes corrupted
  function automatic void gen_chunked();
    int sz;
    put_begin(1'b1, 1'($urandom_range(1)), $urandom());
    repeat ($urandom_range(0, 3)) begin
      sz = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      put_size_line(sz);
      repeat (sz) put_byte(8'($urandom()));
      if ($urandom_range(9) != 0) begin
        put_byte(CHAR_CR);
        put_byte(CHAR_LF);
      end else begin
        put_byte(8'($urandom()));
        put_byte(8'($urandom()));
      end
    end
    put_size_line(0);
    repeat ($urandom_range(0, 6)) put_byte(printable());
    put_byte(CHAR_CR);
    put_byte(CHAR_LF);
    repeat ($urandom_range(0, 3)) put_byte(8'($urandom()));
  endfunction

  // content-length message, mostly short lengths
  function automatic void gen_length(logic k);
    int r;
    int nb;
    logic [31:0] len;
    r = $urandom_range(99);
    if (r < 85) len = $urandom_range(1, 20);
    else if (r < 95) len = '0;
    else len = $urandom();
    put_begin(1'b0, k, len);
    nb = (len <= 20) ? len : $urandom_range(1, 10);
    repeat (nb) put_byte(8'($urandom()));
    repeat ($urandom_range(0, 5)) put_byte(8'($urandom()));
  endfunction

  // size line long enough to saturate
  function automatic void gen_overflow();
    put_begin(1'b1, 1'($urandom_range(1)), $urandom());
    repeat ($urandom_range(9, 12)) put_byte(hex_char(4'($urandom()), 1'($urandom_range(1))));
    put_byte(CHAR_CR);
    put_byte(CHAR_LF);
    repeat ($urandom_range(1, 5)) put_byte(8'($urandom()));
  endfunction

  // move a message to the traffic queue, sometimes cut short or corrupted
  function automatic void flush_msg();
    int n_kept;
    n_kept = msg_q.size();
    if (n_kept > 1 && $urandom_range(99) < 8) n_kept = $urandom_range(1, n_kept - 1);
    if (n_kept > 1 && $urandom_range(99) < 5)
      msg_q[$urandom_range(1, n_kept - 1)].data_byte = 8'($urandom());
    for (int i = 0; i < n_kept; i++) traffic_q.push_back(msg_q[i]);
    msg_q.delete();
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 2);
    if (r < 98) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // present one item and wait for its transfer
  task automatic send_item(stim_t s);
    int gap;
    result_t r;
    if ($urandom_range(149) == 0) no_idle = !no_idle;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0 || s.hold) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if (s.hold) begin
        do @(posedge clk_i); while (pending_results.size() != 0);
      end
    end
    in_valid_i       <= 1'b1;
    op_i             <= s.op;
    data_byte_i      <= s.data_byte;
    chunked_mode_i   <= s.chunked;
    keep_alive_i     <= s.keep;
    content_length_i <= s.len;
    do @(posedge clk_i); while (in_stall_o);
    r = frame_step(s);
    pending_results.push_back(s.typed ? s.known : r);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // result side: compare each transfer, then pick the next stall
  always @(posedge clk_i) begin : result_side
    result_t want;
    int r;
    int stall_left;
    logic stall_on;
    if (rst_ni === 1'b1 && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual byte %0h kind %0d",
                 $time, out_byte_o, kind_o);
      end else begin
        want = pending_results.pop_front();
        check_field("out_byte", 32'(want.out_byte), 32'(out_byte_o));
        check_field("kind", 32'(want.kind), 32'(kind_o));
        check_field("body_done", 32'(want.done), 32'(body_done_o));
        check_field("in_body", 32'(want.in_body), 32'(in_body_o));
        check_field("size_overflow", 32'(want.ovf), 32'(size_overflow_o));
      end
    end
    if (stall_left <= 0) begin
      r = $urandom_range(99);
      if (no_idle || r < 60) begin
        stall_on = 1'b0;
        stall_left = $urandom_range(1, 20);
      end else if (r < 90) begin
        stall_on = 1'b1;
        stall_left = $urandom_range(1, 3);
      end else if (r < 98) begin
        stall_on = 1'b1;
        stall_left = $urandom_range(4, 10);
      end else begin
        stall_on = 1'b1;
        stall_left = $urandom_range(20, 60);
      end
    end
    stall_left--;
    out_stall_i <= stall_on && !no_idle;
  end

  // watchdog on cycles with no transfer on either channel
  initial begin : watchdog
    int idle_cnt;
    idle_cnt = 0;
    while (idle_cnt < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt = 0;
      else idle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int r;
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    op_i             <= OP_BYTE;
    data_byte_i      <= '0;
    chunked_mode_i   <= 1'b0;
    keep_alive_i     <= 1'b0;
    content_length_i <= '0;
    out_stall_i      <= 1'b0;

    // line mode after reset
    row_exp(OP_BYTE, 8'h00, 0, 0, 0, KIND_LINE, 0, 0, 0);
    row_exp(OP_BYTE, 8'hFF, 0, 0, 0, KIND_LINE, 0, 0, 0);
    // empty bodies: kept alive returns at once, close stays in body
    row_exp(OP_BEGIN, 8'h00, 0, 1, 32'h0, KIND_NONE, 1, 0, 0);
    row_exp(OP_BEGIN, 8'h00, 0, 0, 32'h0, KIND_NONE, 1, 1, 0);
    row(OP_BYTE, 8'h55, 0, 0, 0);
    // largest length, then a restart into chunked mode
    row_exp(OP_BEGIN, 8'h00, 0, 1, 32'hFFFF_FFFF, KIND_NONE, 0, 1, 0);
    row(OP_BYTE, 8'h41, 0, 0, 0);
    row_exp(OP_BEGIN, 8'h00, 1, 1, 32'hFFFF_FFFF, KIND_NONE, 0, 1, 0);
    // size saturates on the ninth digit
    repeat (8) row(OP_BYTE, 8'h46, 0, 0, 0);
    row_exp(OP_BYTE, 8'h66, 0, 0, 0, KIND_FRAMING, 0, 1, 1);
    // one-byte chunk with extension, zero chunk, trailer line
    row_exp(OP_BEGIN, 8'h00, 1, 0, 32'h0, KIND_NONE, 0, 1, 0);
    row(OP_BYTE, 8'h31, 0, 0, 0);
    row(OP_BYTE, CHAR_SEMI, 0, 0, 0);
    row(OP_BYTE, 8'h37, 0, 0, 0);
    row(OP_BYTE, CHAR_CR, 0, 0, 0);
    row(OP_BYTE, CHAR_LF, 0, 0, 0);
    row(OP_BYTE, 8'h00, 0, 0, 0);
    row(OP_BYTE, 8'hFF, 0, 0, 0);
    row(OP_BYTE, CHAR_CR, 0, 0, 0);
    row(OP_BYTE, CHAR_ZERO, 0, 0, 0);
    row(OP_BYTE, CHAR_CR, 0, 0, 0);
    row(OP_BYTE, CHAR_LF, 0, 0, 0);
    row(OP_BYTE, 8'h58, 0, 0, 0);
    row(OP_BYTE, CHAR_CR, 0, 0, 0);
    row_exp(OP_BYTE, CHAR_LF, 0, 0, 0, KIND_FRAMING, 1, 0, 0);
    // one-byte length body
    row_exp(OP_BEGIN, 8'h00, 0, 1, 32'h1, KIND_NONE, 0, 1, 0);
    row_exp(OP_BYTE, 8'h80, 0, 0, 0, KIND_PAYLOAD, 1, 0, 0);

    // random messages, mostly well formed
    while (traffic_q.size() < RAND_ITEMS) begin
      r = $urandom_range(99);
      if (r < 45) gen_chunked();
      else if (r < 65) gen_length(1'b1);
      else if (r < 77) gen_length(1'b0);
      else if (r < 83) gen_overflow();
      else begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(3) == 0)
            put_begin(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
          else put_byte(8'($urandom()));
        end
      end
      flush_msg();
    end
    // drain points: sender waits for every result
    for (int i = 0; i < traffic_q.size(); i += 600) traffic_q[i].hold = 1'b1;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_tab[i]) send_item(dir_tab[i]);
    foreach (traffic_q[i]) send_item(traffic_q[i]);
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
